// File: hw/rtl/clae_pkg.sv
// Shared opcodes, status codes and cell control type for the cursor list engine.
package clae_pkg;

    localparam logic [3:0] OP_INSERT  = 4'd0;
    localparam logic [3:0] OP_REMOVE  = 4'd1;
    localparam logic [3:0] OP_REPLACE = 4'd2;
    localparam logic [3:0] OP_CLEAR   = 4'd3;
    localparam logic [3:0] OP_BEGIN   = 4'd4;
    localparam logic [3:0] OP_END     = 4'd5;
    localparam logic [3:0] OP_NEXT    = 4'd6;
    localparam logic [3:0] OP_PRIOR   = 4'd7;
    localparam logic [3:0] OP_READ    = 4'd8;
    localparam logic [3:0] OP_MOVE    = 4'd9;
    localparam logic [3:0] OP_FIND    = 4'd10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_DONE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_BAD_POS  = 3'd4;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_UP   = 2'd1;
    localparam logic [1:0] SH_DN   = 2'd2;

    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [6:0] CAP_RESET    = 7'd64;

    typedef struct packed {
        logic [1:0] shift;
        logic       load;
    } cell_ctl_t;

endpackage

// File: hw/rtl/clae_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags a key match.
module clae_cell
    import clae_pkg::*;
#(
    parameter int IDX = 0,
    parameter int VW  = 32,
    parameter int NW  = 7
)
(
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic [NW-1:0]   lo,
    input  logic [NW-1:0]   hi,
    input  logic [NW-1:0]   ld_idx,
    input  logic [VW-1:0]   ld_val,
    input  logic [VW-1:0]   left_data,
    input  logic [VW-1:0]   right_data,
    input  logic [VW-1:0]   key,
    output logic [VW-1:0]   data,
    output logic            match
);

    localparam logic [NW-1:0] MY = NW'(IDX);

    logic [VW-1:0] data_reg;
    logic [VW-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && ld_idx == MY)
        begin
            data_next = ld_val;
        end
        else
        begin
            case (ctl.shift)
                SH_UP:
                begin
                    if (MY > lo && MY <= hi)
                    begin
                        data_next = left_data;
                    end
                end
                SH_DN:
                begin
                    if (MY >= lo && MY < hi)
                    begin
                        data_next = right_data;
                    end
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

// File: hw/rtl/cursor_array_list_engine.sv
// Top level of the cursor list engine: handshakes, sequencer and the row of slot cells.
//
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+--------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | opcode, element_value, target_position
//  m_*     | out | m_tvalid / m_tready  | status, read_value, cursor, size, empty, full
//  apb     | in  | psel & penable       | capacity_limit at byte address 0
//
//  An operation passes S_EXEC and S_REPORT before the result is registered; find also
//  walks S_FIND one slot per cycle from the cursor on. The scan of the cell match flags
//  sets how long find runs; every shift is done by the whole cell row at once in S_EXEC.
//  One operation is in flight at a time; a new transfer is taken once the result left.
//  Reset clears size, cursor and handshakes and sets capacity to 64; slot contents are not cleared.
//  A stalled result holds in the output register until m_tready.
module cursor_array_list_engine
    import clae_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] opcode, [35:4] element_value, [41:36] target_position, [47:42] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [34:3] read_value, [40:35] cursor_position, [47:41] list_size,
    // [48] is_empty, [49] is_full, [55:50] zero
    output logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FIND   = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [NW-1:0]          count_reg, count_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic [2:0]             st_reg, st_next;
    logic [6:0]             cap_reg;
    logic                   out_valid_reg;

    // latched operation
    logic [3:0]             op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [5:0]             pos_reg;

    // result payload
    logic [2:0]             out_st_reg;
    logic [31:0]            out_val_reg;
    logic [5:0]             out_cur_reg;
    logic [6:0]             out_size_reg;
    logic                   out_empty_reg;
    logic                   out_full_reg;

    // cell row
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    cell_ctl_t              ctl;
    logic [NW-1:0]          lo, hi, ld_idx;
    logic [VALUE_WIDTH-1:0] ld_val;

    logic                   in_xfer, out_xfer, cfg_wr;
    logic [63:0]            in_wide, rd_wide;
    logic [31:0]            count32, cur32, cap32, eff32, pos32;
    logic [VALUE_WIDTH-1:0] cur_data;
    logic [NW-1:0]          cnt_m1;
    logic [CW-1:0]          cur_p1;
    logic                   is_empty, is_full;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_wide  = 64'(s_tdata[35:4]);

    // APB: single register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    // capacity saturates at DEPTH; zero means always full
    assign cap32    = 32'(cap_reg);
    assign eff32    = (cap32 > 32'(DEPTH)) ? 32'(DEPTH) : cap32;
    assign count32  = 32'(count_reg);
    assign cur32    = 32'(cur_reg);
    assign pos32    = 32'(pos_reg);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count32 >= eff32);
    assign cnt_m1   = count_reg - 1'b1;
    assign cur_p1   = cur_reg + 1'b1;
    assign cur_data = cell_data[cur_reg];
    assign rd_wide  = 64'(cur_data);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        scan_next  = scan_reg;
        st_next    = st_reg;
        ctl        = '{shift: SH_NONE, load: 1'b0};
        lo         = '0;
        hi         = '0;
        ld_idx     = '0;
        ld_val     = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPORT;
                st_next    = ST_OK;
                if (op_reg == OP_INSERT)
                begin
                    if (is_full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        // open a gap after the cursor and drop the value in
                        ld_idx     = is_empty ? '0 : NW'(cur_p1);
                        ctl        = '{shift: SH_UP, load: 1'b1};
                        lo         = ld_idx;
                        hi         = count_reg;
                        count_next = count_reg + 1'b1;
                        cur_next   = is_empty ? '0 : cur_p1;
                    end
                end
                else if (op_reg == OP_CLEAR)
                begin
                    count_next = '0;
                    cur_next   = '0;
                end
                else if (op_reg > OP_FIND)
                begin
                    st_next = ST_NOT_DONE;
                end
                else if (is_empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    case (op_reg)
                        OP_REMOVE:
                        begin
                            ctl        = '{shift: SH_DN, load: 1'b0};
                            lo         = NW'(cur_reg);
                            hi         = cnt_m1;
                            count_next = cnt_m1;
                            if (cnt_m1 == '0 || NW'(cur_reg) >= cnt_m1)
                            begin
                                cur_next = '0;
                            end
                        end
                        OP_REPLACE:
                        begin
                            ctl    = '{shift: SH_NONE, load: 1'b1};
                            ld_idx = NW'(cur_reg);
                        end
                        OP_BEGIN:
                        begin
                            cur_next = '0;
                        end
                        OP_END:
                        begin
                            cur_next = cnt_m1[CW-1:0];
                        end
                        OP_NEXT:
                        begin
                            if (cur32 + 32'd1 >= count32)
                            begin
                                st_next = ST_NOT_DONE;
                            end
                            else
                            begin
                                cur_next = cur_p1;
                            end
                        end
                        OP_PRIOR:
                        begin
                            cur_next = (cur_reg == '0) ? cnt_m1[CW-1:0] : cur_reg - 1'b1;
                        end
                        OP_MOVE:
                        begin
                            if (pos32 >= count32)
                            begin
                                st_next = ST_BAD_POS;
                            end
                            else
                            begin
                                // slide the span between cursor and target, land the entry
                                ld_idx = NW'(pos_reg);
                                ld_val = cur_data;
                                if (pos32 < cur32)
                                begin
                                    ctl = '{shift: SH_UP, load: 1'b1};
                                    lo  = NW'(pos_reg);
                                    hi  = NW'(cur_reg);
                                end
                                else
                                begin
                                    ctl = '{shift: SH_DN, load: 1'b1};
                                    lo  = NW'(cur_reg);
                                    hi  = NW'(pos_reg);
                                end
                                cur_next = CW'(pos_reg);
                            end
                        end
                        OP_FIND:
                        begin
                            scan_next  = cur_reg;
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                // walk one slot per cycle; on a miss park on the last entry
                if (match_vec[scan_reg])
                begin
                    cur_next   = scan_reg;
                    st_next    = ST_OK;
                    state_next = S_REPORT;
                end
                else if (32'(scan_reg) + 32'd1 >= count32)
                begin
                    cur_next   = cnt_m1[CW-1:0];
                    st_next    = ST_NOT_DONE;
                    state_next = S_REPORT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // slot cells; the end cells feed back their own entry
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_d, right_d;
        if (g == 0)
        begin : g_first
            assign left_d = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        clae_cell #(
            .IDX (g),
            .VW  (VALUE_WIDTH),
            .NW  (NW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .lo         (lo),
            .hi         (hi),
            .ld_idx     (ld_idx),
            .ld_val     (ld_val),
            .left_data  (left_d),
            .right_data (right_d),
            .key        (val_reg),
            .data       (cell_data[g]),
            .match      (match_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            scan_reg      <= '0;
            st_reg        <= ST_OK;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            scan_reg  <= scan_next;
            st_reg    <= st_next;
            if (cfg_wr)
            begin
                cap_reg <= pwdata[6:0];
            end
            // raise the result after the cells settle, drop it on transfer
            if (state_reg == S_REPORT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operation latch and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= s_tdata[3:0];
            val_reg <= in_wide[VALUE_WIDTH-1:0];
            pos_reg <= s_tdata[41:36];
        end
        if (state_reg == S_REPORT)
        begin
            out_st_reg    <= st_reg;
            out_val_reg   <= is_empty ? 32'd0 : rd_wide[31:0];
            out_cur_reg   <= is_empty ? 6'd0 : cur32[5:0];
            out_size_reg  <= count32[6:0];
            out_empty_reg <= is_empty;
            out_full_reg  <= is_full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_full_reg, out_empty_reg, out_size_reg, out_cur_reg,
                       out_val_reg, out_st_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count32 <= 32'(DEPTH))
        else $error("entry count beyond depth");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg != '0) |-> (cur32 < count32))
        else $error("cursor outside list");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_EXEC))
        else $error("accepted operation not executed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_empty_reg == (out_size_reg == 7'd0)))
        else $error("empty flag disagrees with size");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while operation runs");

endmodule
